### rtl/cst_pkg.sv
`default_nettype none
// Shared types, constants and helpers of the counting segment tree.
package cst_pkg;

    localparam int LEAVES_DEF = 1024;

    localparam int INDEX_W    = 10;
    localparam int POS_W      = 11;
    localparam int LEAF_CNT_W = 11;
    localparam int SUM_W      = 32;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    localparam logic [LEAF_CNT_W-1:0] LEAF_CNT_RST = LEAF_CNT_W'(1024);
    localparam logic [SUM_W-1:0]      SUM_MAX      = '1;

    // one pushed right sibling per tree level at most (depth <= 11)
    localparam int STK_DEPTH = 12;
    localparam int STK_AW    = $clog2(STK_DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_DESC,
        ST_ADD_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_Q_STEP,
        ST_Q_DRAIN,
        ST_Q_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic clr_wr;
        logic desc;
        logic rd_node;
        logic rd_sib;
        logic wr_leaf;
        logic wr_up;
        logic acc_rd;
        logic push;
        logic pop;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_query;
        logic empty;
        logic add_ok;
        logic at_leaf;
        logic at_root;
        logic par_root;
        logic q_disj;
        logic q_full;
        logic stk_empty;
        logic out_free;
    } t_dp_stat;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/cst_ram.sv
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/cst_ctrl.sv
`default_nettype none
// Sequencer of the counting segment tree: clear sweep, add walk, query walk.
module cst_ctrl
    import cst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    input  wire t_dp_stat i_stat,
    output logic          o_s_tready,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_stat.in_query) begin
                        n_state = i_stat.empty ? ST_Q_OUT : ST_Q_STEP;
                    end else if (i_stat.add_ok) begin
                        n_state = ST_ADD_DESC;
                    end
                end
            end
            ST_ADD_DESC: begin
                if (i_stat.at_leaf) n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                n_state = i_stat.at_root ? ST_IDLE : ST_UP_RD;
            end
            ST_UP_RD: begin
                n_state = ST_UP_WR;
            end
            ST_UP_WR: begin
                n_state = i_stat.par_root ? ST_IDLE : ST_UP_RD;
            end
            ST_Q_STEP: begin
                if ((i_stat.q_disj || i_stat.q_full || i_stat.at_leaf) && i_stat.stk_empty) begin
                    n_state = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN: begin
                n_state = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.start = i_s_tvalid;
            end
            ST_ADD_DESC: begin
                if (i_stat.at_leaf) begin
                    o_cmd.rd_node = 1'b1;
                end else begin
                    o_cmd.desc = 1'b1;
                end
            end
            ST_ADD_WR: begin
                o_cmd.wr_leaf = 1'b1;
            end
            ST_UP_RD: begin
                o_cmd.rd_sib = 1'b1;
            end
            ST_UP_WR: begin
                o_cmd.wr_up = 1'b1;
            end
            ST_Q_STEP: begin
                if (i_stat.q_disj || i_stat.q_full || i_stat.at_leaf) begin
                    // node done: fetch its sum if fully covered, then next from stack
                    if (i_stat.q_full && !i_stat.q_disj) begin
                        o_cmd.rd_node = 1'b1;
                        o_cmd.acc_rd  = 1'b1;
                    end
                    o_cmd.pop = !i_stat.stk_empty;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            ST_Q_DRAIN: begin
            end
            ST_Q_OUT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/cst_dp.sv
`default_nettype none
// Datapath of the counting segment tree: node walk, stack, accumulator, RAM ports.
module cst_dp
    import cst_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF,
    localparam int SLOTS = 4 * LEAVES,
    localparam int AW = $clog2(SLOTS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_s_tuser,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tvalid,
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [LEAF_CNT_W-1:0] i_cfg_wr_data,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [SUM_W-1:0]           o_wr_data,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  wire logic [SUM_W-1:0]      i_rd_data
);

    localparam int CAP = (LEAVES < 2047) ? LEAVES : 2047;
    localparam logic [LEAF_CNT_W-1:0] CAP_V = LEAF_CNT_W'(CAP);

    logic [LEAF_CNT_W-1:0] r_leaf_count;
    logic [AW-1:0]         r_clr_addr;
    logic [AW-1:0]         r_node;
    logic [POS_W-1:0]      r_lo;
    logic [POS_W-1:0]      r_hi;
    logic [INDEX_W-1:0]    r_pos;
    logic [POS_W-1:0]      r_qlo;
    logic [POS_W-1:0]      r_qhi;
    logic [SUM_W-1:0]      r_acc;
    logic [SUM_W-1:0]      r_child;
    logic                  r_rd_pend;
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_data;
    logic [STK_AW-1:0]     r_sp;
    logic [AW-1:0]         r_stk_node [STK_DEPTH];
    logic [POS_W-1:0]      r_stk_lo   [STK_DEPTH];
    logic [POS_W-1:0]      r_stk_hi   [STK_DEPTH];

    logic [LEAF_CNT_W-1:0] w_eff;
    logic [INDEX_W-1:0]    w_in_index;
    logic [POS_W-1:0]      w_in_lo;
    logic [POS_W-1:0]      w_in_hi;
    logic [POS_W:0]        w_mid_sum;
    logic [POS_W-1:0]      w_mid;
    logic [AW:0]           w_left_x;
    logic [AW-1:0]         w_left;
    logic [AW-1:0]         w_right;
    logic [AW-1:0]         w_node_m1;
    logic [AW-1:0]         w_parent;
    logic [AW-1:0]         w_sibling;
    logic [STK_AW-1:0]     w_top;
    logic                  w_go_left;
    logic [SUM_W-1:0]      w_leaf_inc;
    logic [SUM_W-1:0]      w_up_sum;

    always_comb begin
        if (r_leaf_count == '0) begin
            w_eff = LEAF_CNT_W'(1);
        end else if (r_leaf_count > CAP_V) begin
            w_eff = CAP_V;
        end else begin
            w_eff = r_leaf_count;
        end
    end

    assign w_in_index = i_s_tdata[INDEX_W-1:0];
    assign w_in_lo    = i_s_tdata[INDEX_W +: POS_W];
    assign w_in_hi    = i_s_tdata[INDEX_W + POS_W +: POS_W];

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[POS_W:1];
    assign w_left_x  = {r_node, 1'b1};
    assign w_left    = w_left_x[AW-1:0];
    assign w_right   = w_left + AW'(1);
    assign w_node_m1 = r_node - AW'(1);
    assign w_parent  = {1'b0, w_node_m1[AW-1:1]};
    // odd node is a left child, its sibling sits one above
    assign w_sibling = r_node[0] ? (r_node + AW'(1)) : w_node_m1;
    assign w_top     = r_sp - STK_AW'(1);
    assign w_go_left = {1'b0, r_pos} < w_mid;
    assign w_leaf_inc = sat_add(i_rd_data, SUM_W'(1));
    assign w_up_sum   = sat_add(r_child, i_rd_data);

    always_comb begin
        o_stat.clr_last  = r_clr_addr == AW'(SLOTS - 1);
        o_stat.in_query  = i_s_tuser;
        o_stat.empty     = w_in_lo >= w_in_hi;
        o_stat.add_ok    = {1'b0, w_in_index} < w_eff;
        o_stat.at_leaf   = (r_hi - r_lo) == POS_W'(1);
        o_stat.at_root   = r_node == '0;
        o_stat.par_root  = w_parent == '0;
        o_stat.q_disj    = (r_qhi <= r_lo) || (r_hi <= r_qlo);
        o_stat.q_full    = (r_qlo <= r_lo) && (r_hi <= r_qhi);
        o_stat.stk_empty = r_sp == '0;
        o_stat.out_free  = !r_out_valid || i_m_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_CNT_RST;
        end else if (i_cfg_wr_en) begin
            r_leaf_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_node <= '0;
            r_lo   <= '0;
            r_hi   <= w_eff;
            r_pos  <= w_in_index;
            r_qlo  <= w_in_lo;
            r_qhi  <= w_in_hi;
        end else if (i_cmd.desc) begin
            if (w_go_left) begin
                r_node <= w_left;
                r_hi   <= w_mid;
            end else begin
                r_node <= w_right;
                r_lo   <= w_mid;
            end
        end else if (i_cmd.push) begin
            r_node <= w_left;
            r_hi   <= w_mid;
        end else if (i_cmd.pop) begin
            r_node <= r_stk_node[w_top];
            r_lo   <= r_stk_lo[w_top];
            r_hi   <= r_stk_hi[w_top];
        end else if (i_cmd.wr_up) begin
            r_node <= w_parent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stk_node[r_sp] <= w_right;
            r_stk_lo[r_sp]   <= w_mid;
            r_stk_hi[r_sp]   <= r_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.start) begin
            r_sp <= '0;
        end else if (i_cmd.push) begin
            r_sp <= r_sp + STK_AW'(1);
        end else if (i_cmd.pop) begin
            r_sp <= w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.acc_rd;
        end
    end

    // read data of a covered node lands in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_rd_pend) begin
            r_acc <= sat_add(r_acc, i_rd_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_leaf) begin
            r_child <= w_leaf_inc;
        end else if (i_cmd.wr_up) begin
            r_child <= w_up_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_acc;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        o_wr_en = i_cmd.clr_wr || i_cmd.wr_leaf || i_cmd.wr_up;
        if (i_cmd.clr_wr) begin
            o_wr_addr = r_clr_addr;
            o_wr_data = '0;
        end else if (i_cmd.wr_leaf) begin
            o_wr_addr = r_node;
            o_wr_data = w_leaf_inc;
        end else begin
            o_wr_addr = w_parent;
            o_wr_data = w_up_sum;
        end
        o_rd_en   = i_cmd.rd_node || i_cmd.rd_sib;
        o_rd_addr = i_cmd.rd_sib ? w_sibling : r_node;
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_sp != STK_AW'(STK_DEPTH - 1)))
        else $error("stack push with no room");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_sp != '0))
        else $error("stack pop while empty");

    a_up_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_up |-> $past(i_cmd.rd_sib))
        else $error("parent write without sibling read");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready) && !r_rd_pend)
        else $error("result loaded over a pending one or before sum landed");

endmodule
`default_nettype wire

### rtl/counting_segment_tree.sv
`default_nettype none
// Top level of the counting segment tree: controller, datapath and node RAM.
//
// Keeps one count per position and answers half-open range-count queries.
// An add transaction (tuser 0) increments the count at index and gives no
// result; a query transaction (tuser 1) gives one 32-bit saturating total.
// All node sums sit in one RAM of 4*LEAVES words with one write and one read
// port, and that port sets the pace. An add walks from its accept down one
// level per step to the leaf, reads and writes the leaf, then reads a sibling
// and writes the parent for each level up; an add outside the tree is
// dropped. A query visits one node per step, and an empty range goes
// straight to the result. One transaction is worked at a time; a finished
// result waits in an output register while the next is taken. After reset
// the RAM is zeroed by a clearing pass over all 4*LEAVES words during which
// s_tready stays low; leaf_count writes are taken at any time.
module counting_segment_tree
    import cst_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // [9:0] index, [20:10] range_low, [31:21] range_high
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    // [0] action
    input  wire logic                  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [31:0] range_total
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [LEAF_CNT_W-1:0] i_cfg_wr_data
);

    localparam int SLOTS = 4 * LEAVES;
    localparam int AW = $clog2(SLOTS);

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [SUM_W-1:0] w_wr_data;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [SUM_W-1:0] w_rd_data;

    cst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    cst_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data)
    );

    cst_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule
`default_nettype wire
